// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttu_pkg.sv =====
package ttu_pkg;

  localparam logic [1:0] FN_SIN  = 2'd0;
  localparam logic [1:0] FN_COS  = 2'd1;
  localparam logic [1:0] FN_ATAN = 2'd2;

  localparam int NumStages = 11;  // input stage, six divider stages, four post stages
  localparam int DivStages = 6;   // four quotient bits per divider stage

  typedef struct packed {
    logic [1:0] func;
    logic       xz;     // x is zero
    logic       yz;     // y is zero
    logic       xn;     // x negative
    logic       yn;     // y negative
    logic       neg;    // sine in the upper half turn
    logic       steep;  // tangent ratio of one or more
  } ctl_t;

  function automatic logic [9:0] sine_lut(input logic [4:0] idx);
    logic [9:0] v;
    unique case (idx)
      5'd0:  v = 10'd0;   5'd1:  v = 10'd50;  5'd2:  v = 10'd98;  5'd3:  v = 10'd142;
      5'd4:  v = 10'd180; 5'd5:  v = 10'd212; 5'd6:  v = 10'd236; 5'd7:  v = 10'd250;
      5'd8:  v = 10'd255; 5'd9:  v = 10'd250; 5'd10: v = 10'd236; 5'd11: v = 10'd212;
      5'd12: v = 10'd180; 5'd13: v = 10'd142; 5'd14: v = 10'd98;  5'd15: v = 10'd50;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] atan_lut(input logic [4:0] idx);
    logic [9:0] v;
    unique case (idx)
      5'd0:  v = 10'd0;   5'd1:  v = 10'd62;  5'd2:  v = 10'd124; 5'd3:  v = 10'd185;
      5'd4:  v = 10'd245; 5'd5:  v = 10'd303; 5'd6:  v = 10'd359; 5'd7:  v = 10'd412;
      5'd8:  v = 10'd464; 5'd9:  v = 10'd512; 5'd10: v = 10'd559; 5'd11: v = 10'd602;
      5'd12: v = 10'd644; 5'd13: v = 10'd682; 5'd14: v = 10'd719; 5'd15: v = 10'd753;
      default: v = 10'd785;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/table_trig_unit.sv =====
// Table-based trig unit in milliradians: sine, cosine and atan2, one word in and one
// word out per cycle. Eleven register stages (input stage, six divider stages, four
// post stages) carry each input word to the output register. The atan2 ratio comes
// from a six-stage restoring divider (four quotient bits per stage); the sine path
// reduces the angle with reciprocal multiplies running alongside it. Both share one
// interpolating table stage. A stalled output freezes the whole pipeline.
`include "assert_macros.svh"

module table_trig_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // angle_or_y[15:0], x_coord[31:16]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // result[13:0], zero pad
);
  import ttu_pkg::*;

  localparam int Last = NumStages - 1;

  logic en;
  logic [NumStages-1:0] vq_q;
  ctl_t ctl_q [NumStages];
  ctl_t ctl_d [NumStages];

  // divider
  logic [23:0] w_q   [DivStages+1];
  logic [23:0] w_d   [DivStages+1];
  logic [15:0] rem_q [DivStages];
  logic [15:0] rem_d [DivStages];
  logic [15:0] dv_q  [DivStages];
  logic [15:0] dv_d  [DivStages];

  // sine reduction
  logic [16:0] v0_q, v0_d, v1_q;
  logic [3:0]  q1_q, q1_d;
  logic [12:0] r2_q, r2_d;
  logic [19:0] n3_q, n3_d, n4_q;
  logic [8:0]  q4_q, q4_d, idx5_q, idx5_d, idx6_q;

  // post stages
  logic [25:0] m7_q, m7_d, m8_q;
  logic [8:0]  pos7_q, pos7_d;
  logic [9:0]  q8_q, q8_d, lo8_q, lo8_d;
  logic signed [15:0] d8_q, d8_d;
  logic signed [11:0] v9_q, v9_d;
  logic [10:0] s9_q, s9_d;
  logic signed [13:0] res_q, res_d;

  function automatic logic [39:0] div_step(input logic [15:0] rem, input logic [23:0] w,
                                           input logic [15:0] d);
    logic [16:0] t;
    logic [15:0] r;
    logic [23:0] ww;
    r  = rem;
    ww = w;
    for (int i = 0; i < 4; i++) begin
      t  = {r, ww[23]};
      ww = {ww[22:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        ww[0] = 1'b1;
      end
      r = t[15:0];
    end
    return {r, ww};
  endfunction

  assign en            = !vq_q[Last] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vq_q[Last];
  assign m_axis_tdata  = {2'b00, res_q};

  always_comb begin
    logic signed [15:0] ang, xin;
    logic signed [18:0] aa;
    logic [39:0] ds;
    logic [30:0] p1;
    logic [16:0] r2;
    logic [11:0] a3;
    logic [40:0] p4;
    logic [20:0] r5;
    logic [15:0] qh;
    logic [4:0]  ti;
    logic [3:0]  off;
    logic [9:0]  lo, hi;
    logic signed [10:0] diff;
    logic [50:0] p8;
    logic signed [15:0] sh;
    logic [25:0] r9;
    logic [9:0]  qq;
    logic signed [13:0] a;
    logic tsel;

    ang = $signed(s_axis_tdata[15:0]);
    xin = $signed(s_axis_tdata[31:16]);

    // stage 0: capture, magnitudes, angle offset so the modulo input is positive
    ctl_d[0]       = '0;
    ctl_d[0].func  = s_axis_tuser;
    ctl_d[0].xz    = (xin == 16'sd0);
    ctl_d[0].yz    = (ang == 16'sd0);
    ctl_d[0].xn    = xin[15];
    ctl_d[0].yn    = ang[15];
    aa    = 19'(ang) + ((s_axis_tuser == FN_COS) ? 19'sd1571 : 19'sd0) + 19'sd37704;
    v0_d  = aa[16:0];
    w_d[0]   = {(ang[15] ? 16'(~ang + 16'sd1) : 16'(ang)), 8'h00};
    rem_d[0] = '0;
    dv_d[0]  = xin[15] ? 16'(~xin + 16'sd1) : 16'(xin);

    for (int k = 1; k < NumStages; k++) ctl_d[k] = ctl_q[k-1];

    for (int k = 1; k < DivStages; k++) begin
      ds       = div_step(rem_q[k-1], w_q[k-1], dv_q[k-1]);
      rem_d[k] = ds[39:24];
      w_d[k]   = ds[23:0];
      dv_d[k]  = dv_q[k-1];
    end
    ds = div_step(rem_q[DivStages-1], w_q[DivStages-1], dv_q[DivStages-1]);
    w_d[DivStages] = ds[23:0];

    // stage 1: quotient estimate for the modulo by two pi
    p1   = 31'(v0_q) * 31'd10679;
    q1_d = p1[29:26];
    // stage 2: remainder with one correction
    r2   = v1_q - 17'(q1_q) * 17'd6284;
    r2_d = (r2 >= 17'd6284) ? 13'(r2 - 17'd6284) : 13'(r2);
    // stage 3: fold at pi, scale to table position
    ctl_d[3].neg = (r2_q >= 13'd3142);
    a3   = ctl_d[3].neg ? 12'(r2_q - 13'd3142) : 12'(r2_q);
    n3_d = {a3, 8'h00} + 20'd1571;
    // stage 4/5: division by pi through a reciprocal
    p4     = 41'(n3_q) * 41'd1366953;
    q4_d   = p4[40:32];
    r5     = 21'(n4_q) - 21'(q4_q) * 21'd3142;
    idx5_d = (r5 >= 21'd3142) ? q4_q + 9'd1 : q4_q;

    // stage 7: table position or steep branch product
    qh   = w_q[DivStages][23:8];
    tsel = (ctl_q[DivStages].func == FN_ATAN);
    ctl_d[7].steep = (qh != 16'd0);
    m7_d   = 26'(qh) * 26'd786;
    pos7_d = tsel ? {1'b0, w_q[DivStages][7:0]} : idx6_q;

    // stage 8: table read and interpolation product; reciprocal for the steep branch
    ti  = pos7_q[8:4];
    off = pos7_q[3:0];
    if (ctl_q[7].func == FN_ATAN) begin
      lo = atan_lut(ti);
      hi = (ti < 5'd16) ? atan_lut(ti + 5'd1) : lo;
    end else begin
      lo = sine_lut(ti);
      hi = (ti < 5'd16) ? sine_lut(ti + 5'd1) : lo;
    end
    diff  = $signed({1'b0, hi}) - $signed({1'b0, lo});
    d8_d  = 16'(diff) * 16'($signed({1'b0, off}));
    lo8_d = lo;
    p8    = 51'(m7_q) * 51'd33819680;
    q8_d  = p8[49:40];

    // stage 9: shift toward zero and add the low entry, finish the steep quotient
    sh   = (d8_q < 0) ? -((-d8_q) >>> 4) : (d8_q >>> 4);
    v9_d = $signed({2'b00, lo8_q}) + 12'(sh);
    r9   = m8_q - 26'(q8_q) * 26'd32511;
    qq   = (r9 >= 26'd32511) ? q8_q + 10'd1 : q8_q;
    s9_d = 11'd785 + 11'(qq);

    // stage 10: sign, axes and quadrant
    a = ctl_q[9].steep ? $signed({3'b000, s9_q}) : 14'(v9_q);
    unique case (ctl_q[9].func)
      FN_SIN, FN_COS: res_d = ctl_q[9].neg ? -14'(v9_q) : 14'(v9_q);
      FN_ATAN: begin
        if (ctl_q[9].xz)      res_d = ctl_q[9].yn ? -14'sd1571 : 14'sd1571;
        else if (ctl_q[9].yz) res_d = ctl_q[9].xn ? 14'sd3142 : 14'sd0;
        else if (ctl_q[9].xn) res_d = ctl_q[9].yn ? 14'sd3142 + a : 14'sd3142 - a;
        else if (ctl_q[9].yn) res_d = 14'sd6284 - a;
        else                  res_d = a;
      end
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= '0;
    end else if (en) begin
      vq_q <= {vq_q[Last-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NumStages; k++) ctl_q[k] <= ctl_d[k];
      for (int k = 0; k <= DivStages; k++) w_q[k] <= w_d[k];
      for (int k = 0; k < DivStages; k++) begin
        rem_q[k] <= rem_d[k];
        dv_q[k]  <= dv_d[k];
      end
      v0_q   <= v0_d;
      v1_q   <= v0_q;
      q1_q   <= q1_d;
      r2_q   <= r2_d;
      n3_q   <= n3_d;
      n4_q   <= n3_q;
      q4_q   <= q4_d;
      idx5_q <= idx5_d;
      idx6_q <= idx5_q;
      m7_q   <= m7_d;
      pos7_q <= pos7_d;
      m8_q   <= m7_q;
      q8_q   <= q8_d;
      lo8_q  <= lo8_d;
      d8_q   <= d8_d;
      v9_q   <= v9_d;
      s9_q   <= s9_d;
      res_q  <= res_d;
    end
  end

  `ASSERT_CLK(a_stage_advance, en |=> vq_q[1] == $past(vq_q[0]), "valid lost in pipeline")
  `ASSERT_IMPL(a_sine_index, vq_q[5], idx5_q <= 9'd256, "sine table index beyond range")
  `ASSERT_IMPL(a_sine_range,
               vq_q[Last] && (ctl_q[Last].func == FN_SIN || ctl_q[Last].func == FN_COS),
               res_q <= 14'sd255 && res_q >= -14'sd255, "sine result out of range")

endmodule
